FILE: sv/phe_pkg.sv
// shared constants, types and saturation helpers of the polynomial evaluator
package phe_pkg;

  localparam int DEF_MAX_TERMS = 7;
  localparam int DEF_FRAC_BITS = 16;

  localparam int NUM_COEFF = 7;
  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 3;
  localparam int INDEX_W   = 3;
  localparam int TDATA_W   = 40;

  localparam logic [INDEX_W-1:0] REG_COEFF_COUNT = 3'd0;

  localparam logic signed [64:0] WIDE_MAX = 65'sd2147483647;
  localparam logic signed [64:0] WIDE_MIN = -65'sd2147483648;
  localparam logic signed [32:0] SUM_MAX  = 33'sd2147483647;
  localparam logic signed [32:0] SUM_MIN  = -33'sd2147483648;

  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     ovf;
  } sat_t;

  // clamp a shifted product to the word range
  function automatic sat_t sat_wide(input logic signed [64:0] v);
    sat_t r;
    if (v > WIDE_MAX) begin
      r.val = 32'sh7fffffff;
      r.ovf = 1'b1;
    end else if (v < WIDE_MIN) begin
      r.val = 32'sh80000000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // clamp a 33-bit sum to the word range
  function automatic sat_t sat_sum(input logic signed [32:0] v);
    sat_t r;
    if (v > SUM_MAX) begin
      r.val = 32'sh7fffffff;
      r.ovf = 1'b1;
    end else if (v < SUM_MIN) begin
      r.val = 32'sh80000000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: sv/polynomial_horner_evaluator.sv
// Horner polynomial evaluator and power-term generator, signed fixed point.
// The block takes one sample per cycle unless the pipeline stalls. Each Horner step has
// a stage of its own, split in a multiply register and a round / saturate / add-coefficient
// register, so an item passes an input register, 2*(MAX_TERMS-1) step registers and the
// output register; evaluate results leave one per cycle while m_tready is high. In powers
// mode the same step chain builds x^1..x^(MAX_TERMS-1) along the way, and the output
// register sends max(min(coeff_count, MAX_TERMS), 1) terms, one per cycle while m_tready is
// high, so such an item holds the output until its last term is taken, and the pipeline
// stalls behind it. Unused leading coefficients enter the chain as zero, which leaves the
// Horner result unchanged. Coefficients are written through the cfg channel (index 0 count,
// 1..7 coefficients), reset to zero. Write only while the block is idle; it is not enforced.
module polynomial_horner_evaluator
  import phe_pkg::*;
#(
  parameter int MAX_TERMS = DEF_MAX_TERMS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [INDEX_W-1:0]       cfg_index,
  input  logic [WORD_W-1:0]        cfg_data,
  // input stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [WORD_W-1:0]        s_tdata,   // [31:0] x_value
  input  logic                     s_tuser,   // [0] cmd
  // result stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [TDATA_W-1:0]       m_tdata,   // [31:0] result_value, [34:32] term_index
  output logic                     m_tuser,   // [0] overflow
  output logic                     m_tlast
);

  localparam int STEPS = MAX_TERMS - 1;
  localparam int NODES = 2 * STEPS + 1;
  localparam int IW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int HSH   = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam logic signed [64:0] HALF = (FRAC_BITS > 0) ? (65'sd1 <<< HSH) : 65'sd0;
  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(64'sd1 <<< FRAC_BITS);

  typedef struct packed {
    logic                              cmd;
    logic [COUNT_W-1:0]                n;
    logic signed [WORD_W-1:0]          x;
    logic signed [WORD_W-1:0]          y;
    logic                              ovf;
    logic signed [63:0]                prod;
    logic [MAX_TERMS-1:0][WORD_W-1:0]  terms;
    logic [MAX_TERMS-1:0]              tovf;
  } item_t;

  logic [COUNT_W-1:0]       coeff_count;
  logic signed [WORD_W-1:0] coeff [0:NUM_COEFF-1];

  item_t node       [0:NODES-1];
  logic  node_valid [0:NODES-1];
  logic  node_ready [0:NODES];

  item_t              ob;
  logic               ob_valid;
  logic [INDEX_W-1:0] ob_idx;
  logic               ob_last;
  logic               ob_load;

  logic [COUNT_W-1:0]       n_in;
  logic signed [WORD_W-1:0] y_init;
  item_t                    in_item;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_count <= '0;
      for (int i = 0; i < NUM_COEFF; i++) begin
        coeff[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COEFF_COUNT) begin
        coeff_count <= cfg_data[COUNT_W-1:0];
      end else begin
        coeff[3'(cfg_index - 3'd1)] <= cfg_data;
      end
    end
  end

  // stage ready chain: a stage takes data when empty or when it moves on
  always_comb begin
    node_ready[NODES] = ob_load;
    for (int k = NODES - 1; k >= 0; k--) begin
      node_ready[k] = !node_valid[k] || node_ready[k+1];
    end
  end

  assign s_tready = node_ready[0];

  // input register
  always_comb begin
    n_in = (coeff_count > COUNT_W'(MAX_TERMS)) ? COUNT_W'(MAX_TERMS) : coeff_count;
    if (s_tuser) begin
      y_init = ONE;
    end else if (n_in == COUNT_W'(MAX_TERMS)) begin
      y_init = coeff[MAX_TERMS-1];
    end else begin
      y_init = '0;
    end
    in_item          = '0;
    in_item.cmd      = s_tuser;
    in_item.n        = n_in;
    in_item.x        = s_tdata;
    in_item.y        = y_init;
    in_item.terms[0] = ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid[0] <= 1'b0;
    end else if (node_ready[0]) begin
      node_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (node_ready[0]) begin
      node[0] <= in_item;
    end
  end

  // one multiply register and one round/add register per Horner step
  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam int M  = 2 * j - 1;
    localparam int P  = 2 * j;
    localparam int CI = STEPS - j;

    logic signed [64:0]       rnd;
    logic signed [64:0]       shv;
    logic signed [WORD_W-1:0] cf;
    logic signed [32:0]       sum;
    sat_t                     ps;
    sat_t                     ss;
    item_t                    mul_item;
    item_t                    add_item;

    always_ff @(posedge clk) begin
      if (rst) begin
        node_valid[M] <= 1'b0;
        node_valid[P] <= 1'b0;
      end else begin
        if (node_ready[M]) begin
          node_valid[M] <= node_valid[M-1];
        end
        if (node_ready[P]) begin
          node_valid[P] <= node_valid[M];
        end
      end
    end

    always_comb begin
      mul_item      = node[M-1];
      mul_item.prod = node[M-1].y * node[M-1].x;
    end

    always_ff @(posedge clk) begin
      if (node_ready[M]) begin
        node[M] <= mul_item;
      end
    end

    always_comb begin
      rnd = 65'(node[M].prod) + HALF;
      shv = rnd >>> FRAC_BITS;
      ps  = sat_wide(shv);
      // powers mode and coefficients above the count add zero
      cf  = (!node[M].cmd && (node[M].n > COUNT_W'(CI))) ? coeff[CI] : '0;
      sum = 33'(ps.val) + 33'(cf);
      ss  = sat_sum(sum);
      add_item          = node[M];
      add_item.y        = ss.val;
      add_item.ovf      = node[M].ovf | ps.ovf | ss.ovf;
      add_item.terms[j] = ss.val;
      add_item.tovf[j]  = node[M].ovf | ps.ovf | ss.ovf;
    end

    always_ff @(posedge clk) begin
      if (node_ready[P]) begin
        node[P] <= add_item;
      end
    end
  end

  // output register, sends the evaluate result or the power terms one transfer at a time
  always_comb begin
    if (ob.cmd) begin
      ob_last = (ob.n == '0) || (ob_idx == 3'(ob.n - 3'd1));
    end else begin
      ob_last = 1'b1;
    end
    ob_load = !ob_valid || (m_tready && ob_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_idx   <= '0;
    end else if (ob_load) begin
      ob_valid <= node_valid[NODES-1];
      ob_idx   <= '0;
    end else if (m_tready) begin
      ob_idx <= ob_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_load) begin
      ob <= node[NODES-1];
    end
  end

  always_comb begin
    m_tvalid = ob_valid;
    m_tlast  = ob_last;
    if (ob.cmd) begin
      m_tdata = {5'd0, ob_idx, ob.terms[ob_idx[IW-1:0]]};
      m_tuser = ob.tovf[ob_idx[IW-1:0]];
    end else begin
      m_tdata = {5'd0, 3'd0, ob.y};
      m_tuser = ob.ovf;
    end
  end

endmodule
